[sv/fbat_pkg.sv]
// ----------------------------------------------------------------------------
// fbat_pkg
// Operation codes, free-state codes and id generator constants of the
// flash block allocation table.
// ----------------------------------------------------------------------------
`default_nettype none

package fbat_pkg;

  localparam logic [3:0] K_LOAD    = 4'd0;
  localparam logic [3:0] K_PURGE   = 4'd1;
  localparam logic [3:0] K_LOOKUP  = 4'd2;
  localparam logic [3:0] K_ACQUIRE = 4'd3;
  localparam logic [3:0] K_DELETE  = 4'd4;
  localparam logic [3:0] K_INFO    = 4'd5;
  localparam logic [3:0] K_ITERATE = 4'd6;
  localparam logic [3:0] K_NEWID   = 4'd7;
  localparam logic [3:0] K_WIPE    = 4'd8;
  localparam logic [3:0] K_PENDING = 4'd9;
  localparam logic [3:0] K_VERSION = 4'd10;
  localparam logic [3:0] K_STATUS  = 4'd11;

  localparam logic [15:0] FS_ERASED  = 16'h0000;
  localparam logic [15:0] FS_MAYBE   = 16'h0001;
  localparam logic [15:0] FS_UNKNOWN = 16'h0002;
  localparam logic [15:0] FS_GARBAGE = 16'h0003;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_INC = 32'd1013904223;

  localparam int unsigned ID_SPACE = 65536;

  typedef logic [15:0] id_t;

endpackage

`default_nettype wire

[sv/flash_block_allocation_table.sv]
// ----------------------------------------------------------------------------
// flash_block_allocation_table
// Per-block owner / free-state table with sticky version bits and an id seed.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over its memories and takes no
// transfer until it ends; configuration writes are taken at any time. One
// operation is worked on at a time. Lookup, acquire, delete, info, iterate,
// wipe, pending and status read one table entry per cycle from the entry
// memory, up to entry n = min(blocks_in_use, MAX_BLOCKS); a scan can stop
// early. Purge makes three passes over the table (mark part-0 owners in an
// owner bitmap, free orphans, unmark). Newid marks all owners, draws
// candidate ids in a draw state and a check state, and unmarks. A finished
// result waits in the output register while the next operation is taken.
`default_nettype none

module flash_block_allocation_table
  import fbat_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS  = 1024,
  parameter int unsigned NO_OWNER_ID = 0
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [10:0] cfg_wdata_i,      // blocks_in_use
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // block_number[9:0], owner_id[25:10], part_index[41:26], zero[47:42]
  input  wire  [47:0] s_axis_tdata_i,
  // kind[3:0], header_valid[4], header_blank[5], header_new_format[6],
  // erase_request[7]
  input  wire  [7:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // result_block[9:0], result_owner[25:10], next_start[36:26],
  // part_count[53:37], used_count[64:54], erased_count[75:65], zero[79:76]
  output logic [79:0] m_axis_tdata_o,
  // found[0], flag_out[1], table_full[2]
  output logic [2:0]  m_axis_tuser_o
);

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam id_t NO_OWN = id_t'(NO_OWNER_ID);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SINGLE = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_DRAW   = 4'd4;
  localparam logic [3:0] S_CHECK  = 4'd5;
  localparam logic [3:0] S_DONE   = 4'd6;

  localparam logic [1:0] PASS_MAIN   = 2'd0;
  localparam logic [1:0] PASS_MARK   = 2'd1;
  localparam logic [1:0] PASS_FIX    = 2'd2;
  localparam logic [1:0] PASS_UNMARK = 2'd3;

  logic [3:0]  state_q, state_d;
  logic [1:0]  pass_q, pass_d;
  logic [10:0] cfg_q;
  logic [15:0] clr_q, clr_d;
  logic [10:0] rd_q, rd_d;
  logic        pv_q, pv_d;
  logic [10:0] pi_q, pi_d;
  logic        stop_q, stop_d;
  logic        p2v_q, p2v_d;
  logic [10:0] p2i_q, p2i_d;
  logic [32:0] p2e_q, p2e_d;
  logic [16:0] tries_q, tries_d;
  logic [31:0] seed_q, seed_d;

  logic [3:0]  kind_q, kind_d;
  logic [9:0]  blk_q, blk_d;
  id_t         own_q, own_d;
  logic [15:0] part_q, part_d;
  logic        hval_q, hval_d;
  logic        hblank_q, hblank_d;
  logic        hnew_q, hnew_d;
  logic        ereq_q, ereq_d;

  logic        found_q, found_d;
  logic [10:0] rblk_q, rblk_d;
  id_t         rown_q, rown_d;
  logic [10:0] next_q, next_d;
  logic [15:0] maxp_q, maxp_d;
  logic [15:0] bst_q, bst_d;
  logic        flag_q, flag_d;
  logic [10:0] used_q, used_d;
  logic [10:0] erased_q, erased_d;
  logic        full_q, full_d;

  logic        mvalid_q, mvalid_d;
  logic [79:0] mdata_q, mdata_d;
  logic [2:0]  muser_q, muser_d;

  logic          e_we;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [32:0]   e_wdata, e_rdata;
  logic          b_we;
  logic [15:0]   b_waddr, b_raddr;
  logic          b_wdata, b_rdata;

  logic [10:0] n_w;
  logic [31:0] lcg_next;
  logic [31:0] ent;
  logic        ent_v;
  id_t         ent_o;
  logic [15:0] ent_l;
  logic        ent_free;
  logic        issue;
  logic        hit;
  logic        mark_cond;
  logic        scan_end;
  logic [31:0] new_ent;

  assign n_w = (32'(cfg_q) < 32'(MAX_BLOCKS)) ? cfg_q : 11'(MAX_BLOCKS);
  assign lcg_next = seed_q * LCG_MUL + LCG_INC;
  assign ent = e_rdata[31:0];
  assign ent_v = e_rdata[32];
  assign ent_o = ent[31:16];
  assign ent_l = ent[15:0];
  assign ent_free = (ent_o == NO_OWN);
  assign issue = !stop_q && (rd_q < n_w);
  assign mark_cond = (kind_q == K_NEWID) || (!ent_free && ent_l == FS_ERASED);
  assign scan_end = (stop_q || !(rd_q < n_w)) && !pv_q && !p2v_q;
  assign new_ent = hval_q ? {own_q, part_q} : {NO_OWN, hblank_q ? FS_MAYBE : FS_UNKNOWN};

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = muser_q;

  fbat_ram #(.WIDTH(33), .DEPTH(MAX_BLOCKS)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  fbat_ram #(.WIDTH(1), .DEPTH(ID_SPACE)) u_owner_map (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  always_comb begin
    state_d = state_q;
    pass_d = pass_q;
    clr_d = clr_q;
    rd_d = rd_q;
    pv_d = 1'b0;
    pi_d = pi_q;
    stop_d = stop_q;
    p2v_d = 1'b0;
    p2i_d = p2i_q;
    p2e_d = p2e_q;
    tries_d = tries_q;
    seed_d = seed_q;
    kind_d = kind_q;
    blk_d = blk_q;
    own_d = own_q;
    part_d = part_q;
    hval_d = hval_q;
    hblank_d = hblank_q;
    hnew_d = hnew_q;
    ereq_d = ereq_q;
    found_d = found_q;
    rblk_d = rblk_q;
    rown_d = rown_q;
    next_d = next_q;
    maxp_d = maxp_q;
    bst_d = bst_q;
    flag_d = flag_q;
    used_d = used_q;
    erased_d = erased_q;
    full_d = full_q;
    mvalid_d = mvalid_q;
    mdata_d = mdata_q;
    muser_d = muser_q;
    e_we = 1'b0;
    e_waddr = '0;
    e_wdata = '0;
    e_raddr = '0;
    b_we = 1'b0;
    b_waddr = '0;
    b_wdata = 1'b0;
    b_raddr = '0;
    hit = 1'b0;

    if (mvalid_q && m_axis_tready_i) begin
      mvalid_d = 1'b0;
    end

    case (state_q)
      S_CLR: begin
        if (32'(clr_q) < 32'(MAX_BLOCKS)) begin
          e_we = 1'b1;
          e_waddr = AW'(clr_q);
        end
        b_we = 1'b1;
        b_waddr = clr_q;
        clr_d = clr_q + 16'd1;
        if (clr_q == 16'hffff) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          kind_d = s_axis_tuser_i[3:0];
          hval_d = s_axis_tuser_i[4];
          hblank_d = s_axis_tuser_i[5];
          hnew_d = s_axis_tuser_i[6];
          ereq_d = s_axis_tuser_i[7];
          blk_d = s_axis_tdata_i[9:0];
          own_d = s_axis_tdata_i[25:10];
          part_d = s_axis_tdata_i[41:26];
          found_d = 1'b0;
          rblk_d = '0;
          rown_d = '0;
          next_d = '0;
          maxp_d = '0;
          bst_d = '0;
          used_d = '0;
          erased_d = '0;
          full_d = (s_axis_tuser_i[3:0] == K_STATUS);
          flag_d = (s_axis_tuser_i[3:0] == K_WIPE) && s_axis_tuser_i[7];
          stop_d = 1'b0;
          rd_d = '0;
          pass_d = PASS_MAIN;
          case (s_axis_tuser_i[3:0])
            K_LOAD, K_VERSION: begin
              if ({1'b0, s_axis_tdata_i[9:0]} < n_w) begin
                e_raddr = AW'(s_axis_tdata_i[9:0]);
                state_d = S_SINGLE;
              end else begin
                state_d = S_DONE;
              end
            end
            K_PURGE, K_NEWID: begin
              pass_d = PASS_MARK;
              state_d = S_SCAN;
            end
            K_LOOKUP, K_ACQUIRE, K_DELETE, K_INFO, K_STATUS: begin
              state_d = S_SCAN;
            end
            K_ITERATE, K_WIPE, K_PENDING: begin
              rd_d = {1'b0, s_axis_tdata_i[9:0]};
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SINGLE: begin
        found_d = 1'b1;
        rblk_d = {1'b0, blk_q};
        if (kind_q == K_LOAD) begin
          e_we = 1'b1;
          e_waddr = AW'(blk_q);
          e_wdata = {ent_v | hnew_q, new_ent};
          seed_d = seed_q ^ new_ent;
        end else begin
          flag_d = ent_v;
        end
        state_d = S_DONE;
      end

      S_SCAN: begin
        if (pv_q) begin
          case (pass_q)
            PASS_MAIN: begin
              case (kind_q)
                K_LOOKUP: begin
                  if (ent == {own_q, part_q}) begin
                    found_d = 1'b1;
                    rblk_d = pi_q;
                    hit = 1'b1;
                  end
                end
                K_ACQUIRE: begin
                  if (ent_free) begin
                    if (!found_q || ent_l < bst_q) begin
                      found_d = 1'b1;
                      rblk_d = pi_q;
                      bst_d = ent_l;
                    end
                    if (ent_l == FS_ERASED) begin
                      hit = 1'b1;
                    end
                  end
                end
                K_DELETE: begin
                  if (ent_o == own_q) begin
                    if (ent_l == FS_ERASED) begin
                      found_d = 1'b1;
                      rblk_d = pi_q;
                    end
                    e_we = 1'b1;
                    e_waddr = AW'(pi_q);
                    e_wdata = {ent_v, NO_OWN,
                               (ent_l == FS_ERASED) ? FS_ERASED : FS_GARBAGE};
                  end
                end
                K_INFO: begin
                  if (ent_o == own_q) begin
                    if (!found_q || ent_l > maxp_q) begin
                      rblk_d = pi_q;
                      maxp_d = ent_l;
                    end
                    found_d = 1'b1;
                  end
                end
                K_ITERATE: begin
                  if (!ent_free && ent_l == FS_ERASED) begin
                    found_d = 1'b1;
                    rblk_d = pi_q;
                    rown_d = ent_o;
                    next_d = pi_q + 11'd1;
                    hit = 1'b1;
                  end
                end
                K_WIPE: begin
                  if (!ent_free) begin
                    e_we = 1'b1;
                    e_waddr = AW'(pi_q);
                    e_wdata = {ent_v, NO_OWN,
                               (ereq_q || ent_l == FS_ERASED) ? FS_ERASED : FS_GARBAGE};
                    found_d = 1'b1;
                    rblk_d = pi_q;
                    flag_d = ereq_q || ent_l == FS_ERASED;
                    hit = 1'b1;
                  end
                end
                K_PENDING: begin
                  if (ent_free && ent_l != FS_ERASED) begin
                    e_we = 1'b1;
                    e_waddr = AW'(pi_q);
                    e_wdata = {ent_v, NO_OWN, FS_ERASED};
                    found_d = 1'b1;
                    rblk_d = pi_q;
                    hit = 1'b1;
                  end
                end
                K_STATUS: begin
                  if (ent_free) begin
                    full_d = 1'b0;
                  end else begin
                    used_d = used_q + 11'd1;
                  end
                  if (ent == {NO_OWN, FS_ERASED}) begin
                    erased_d = erased_q + 11'd1;
                  end
                end
                default: ;
              endcase
            end
            PASS_MARK, PASS_UNMARK: begin
              if (mark_cond) begin
                b_we = 1'b1;
                b_waddr = ent_o;
                b_wdata = (pass_q == PASS_MARK);
              end
            end
            PASS_FIX: begin
              if (!ent_free && ent_l != FS_ERASED) begin
                p2v_d = 1'b1;
                p2i_d = pi_q;
                p2e_d = e_rdata;
                b_raddr = ent_o;
              end
            end
            default: ;
          endcase
        end

        // orphan without a part-0 block of its owner becomes garbage
        if (p2v_q && !b_rdata) begin
          e_we = 1'b1;
          e_waddr = AW'(p2i_q);
          e_wdata = {p2e_q[32], NO_OWN, FS_GARBAGE};
        end

        e_raddr = AW'(rd_q);
        if (issue) begin
          rd_d = rd_q + 11'd1;
        end
        pv_d = issue && !hit;
        pi_d = rd_q;
        if (hit) begin
          stop_d = 1'b1;
        end

        if (scan_end) begin
          rd_d = '0;
          stop_d = 1'b0;
          case (pass_q)
            PASS_MAIN: begin
              if (kind_q == K_ACQUIRE && found_q) begin
                e_we = 1'b1;
                e_waddr = AW'(rblk_q);
                e_wdata = {1'b1, own_q, part_q};
              end
              state_d = S_DONE;
            end
            PASS_MARK: begin
              if (kind_q == K_NEWID) begin
                tries_d = '0;
                state_d = S_DRAW;
              end else begin
                pass_d = PASS_FIX;
              end
            end
            PASS_FIX: begin
              pass_d = PASS_UNMARK;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_DRAW: begin
        seed_d = lcg_next;
        b_raddr = lcg_next[15:0];
        tries_d = tries_q + 17'd1;
        state_d = S_CHECK;
      end

      S_CHECK: begin
        if (seed_q[15:0] != NO_OWN && !b_rdata) begin
          found_d = 1'b1;
          rown_d = seed_q[15:0];
          pass_d = PASS_UNMARK;
          state_d = S_SCAN;
        end else if (tries_q == 17'(ID_SPACE)) begin
          pass_d = PASS_UNMARK;
          state_d = S_SCAN;
        end else begin
          state_d = S_DRAW;
        end
      end

      S_DONE: begin
        if (!mvalid_q || m_axis_tready_i) begin
          mvalid_d = 1'b1;
          mdata_d = {4'd0, erased_q, used_q,
                     (kind_q == K_INFO && found_q) ? ({1'b0, maxp_q} + 17'd1) : 17'd0,
                     next_q, rown_q, rblk_q[9:0]};
          muser_d = {full_q,
                     (kind_q == K_ACQUIRE) ? (found_q && bst_q == FS_ERASED) : flag_q,
                     found_q};
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      pass_q <= PASS_MAIN;
      cfg_q <= 11'd1024;
      clr_q <= '0;
      rd_q <= '0;
      pv_q <= 1'b0;
      stop_q <= 1'b0;
      p2v_q <= 1'b0;
      tries_q <= '0;
      seed_q <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q <= pass_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      clr_q <= clr_d;
      rd_q <= rd_d;
      pv_q <= pv_d;
      stop_q <= stop_d;
      p2v_q <= p2v_d;
      tries_q <= tries_d;
      seed_q <= seed_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pi_q <= pi_d;
    p2i_q <= p2i_d;
    p2e_q <= p2e_d;
    kind_q <= kind_d;
    blk_q <= blk_d;
    own_q <= own_d;
    part_q <= part_d;
    hval_q <= hval_d;
    hblank_q <= hblank_d;
    hnew_q <= hnew_d;
    ereq_q <= ereq_d;
    found_q <= found_d;
    rblk_q <= rblk_d;
    rown_q <= rown_d;
    next_q <= next_d;
    maxp_q <= maxp_d;
    bst_q <= bst_d;
    flag_q <= flag_d;
    used_q <= used_d;
    erased_q <= erased_d;
    full_q <= full_d;
    mdata_q <= mdata_d;
    muser_q <= muser_d;
  end

  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> state_q == S_SCAN)
    else $error("entry read in flight outside a scan");

  a_stage2_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2v_q |-> (state_q == S_SCAN && pass_q == PASS_FIX))
    else $error("orphan check outside the fix pass");

  a_stop_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |-> !pv_q)
    else $error("entry read kept after scan stop");

  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!mvalid_q || m_axis_tready_i)) |=>
      (m_axis_tvalid_o && state_q == S_IDLE))
    else $error("result not presented at end of operation");

endmodule

`default_nettype wire

[sv/fbat_ram.sv]
// ----------------------------------------------------------------------------
// fbat_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fbat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for flash_block_allocation_table. Every covered block is
// first loaded so that no scan ever reads an unwritten entry. A table of
// directed operations follows, then random traffic under three idle patterns
// and a long output stall. Each result transfer is checked field by field
// against a behavioral table copy in the bench or a row's given answer.
// ----------------------------------------------------------------------------
module tb_top;
  import fbat_pkg::*;

  localparam int unsigned TABLE_SIZE = 1024;
  localparam int unsigned PRELOAD = 256;
  localparam int unsigned NO_OWNER_ID = 0;
  localparam int unsigned STALL_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 4000;

  typedef struct {
    logic [3:0]  kind;
    logic [9:0]  blk;
    logic [15:0] owner;
    logic [15:0] part;
    logic        valid;
    logic        blank;
    logic        newf;
    logic        ereq;
  } op_t;

  typedef struct {
    logic        found;
    logic [9:0]  blk;
    logic [15:0] owner;
    logic [10:0] next_blk;
    logic [16:0] parts;
    logic        flag;
    logic [10:0] used;
    logic [10:0] erased;
    logic        full;
  } answer_t;

  typedef struct {
    int      cfg;
    op_t     op;
    bit      typed;
    answer_t ans;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic [7:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  flash_block_allocation_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  // bench copy of the table
  logic [31:0] entry_mem [TABLE_SIZE];
  logic        version_mem [TABLE_SIZE];
  logic [31:0] seed;
  int unsigned blocks_cfg;
  bit          owner_mark [65536];

  answer_t     pending_answers[$];
  int unsigned error_count;
  int unsigned src_idle;
  int unsigned sink_idle;
  logic        hold_on = 1'b0;
  bit          hold_go;
  int unsigned quiet_cycles;
  row_t        rows[$];

  function automatic answer_t table_step(op_t op);
    answer_t     a;
    int unsigned n;
    logic [31:0] e;
    logic [31:0] want;
    logic [15:0] best_state;
    logic [15:0] maxp;
    logic [15:0] id;
    bit          got;
    bit          er;
    int          best;
    a = '{default: '0};
    n = (blocks_cfg < TABLE_SIZE) ? blocks_cfg : TABLE_SIZE;
    got = 0;
    best = 0;
    best_state = '0;
    maxp = '0;
    want = {op.owner, op.part};
    case (op.kind)
      K_LOAD: begin
        if (op.blk < n) begin
          entry_mem[op.blk] = op.valid ? {op.owner, op.part} :
                              {16'(NO_OWNER_ID), op.blank ? FS_MAYBE : FS_UNKNOWN};
          if (op.newf) version_mem[op.blk] = 1'b1;
          seed ^= entry_mem[op.blk];
          a.found = 1'b1;
          a.blk = op.blk;
        end
      end
      K_PURGE: begin
        owner_mark = '{default: 0};
        for (int i = 0; i < n; i++)
          if (entry_mem[i][31:16] != NO_OWNER_ID && entry_mem[i][15:0] == 0)
            owner_mark[entry_mem[i][31:16]] = 1;
        for (int i = 0; i < n; i++) begin
          e = entry_mem[i];
          if (e[31:16] != NO_OWNER_ID && e[15:0] != 0 && !owner_mark[e[31:16]])
            entry_mem[i] = {16'(NO_OWNER_ID), FS_GARBAGE};
        end
      end
      K_LOOKUP: begin
        for (int i = 0; i < n; i++)
          if (entry_mem[i] == want) begin
            a.found = 1'b1;
            a.blk = i;
            break;
          end
      end
      K_ACQUIRE: begin
        for (int i = 0; i < n; i++) begin
          e = entry_mem[i];
          if (e[31:16] != NO_OWNER_ID) continue;
          if (!got || e[15:0] < best_state) begin
            got = 1;
            best = i;
            best_state = e[15:0];
          end
          if (e[15:0] == FS_ERASED) break;
        end
        if (got) begin
          entry_mem[best] = want;
          version_mem[best] = 1'b1;
          a.found = 1'b1;
          a.blk = best;
          a.flag = (best_state == FS_ERASED);
        end
      end
      K_DELETE: begin
        for (int i = 0; i < n; i++) begin
          e = entry_mem[i];
          if (e[31:16] != op.owner) continue;
          if (e[15:0] == 0) begin
            a.found = 1'b1;
            a.blk = i;
          end
          entry_mem[i] = {16'(NO_OWNER_ID), (e[15:0] == 0) ? FS_ERASED : FS_GARBAGE};
        end
      end
      K_INFO: begin
        for (int i = 0; i < n; i++) begin
          e = entry_mem[i];
          if (e[31:16] != op.owner) continue;
          if (!a.found || e[15:0] > maxp) begin
            a.blk = i;
            maxp = e[15:0];
          end
          a.found = 1'b1;
        end
        if (a.found) a.parts = 17'(maxp) + 17'd1;
      end
      K_ITERATE: begin
        for (int i = op.blk; i < n; i++) begin
          e = entry_mem[i];
          if (e[31:16] == NO_OWNER_ID || e[15:0] != 0) continue;
          a.found = 1'b1;
          a.blk = i;
          a.owner = e[31:16];
          a.next_blk = i + 1;
          break;
        end
      end
      K_NEWID: begin
        owner_mark = '{default: 0};
        for (int i = 0; i < n; i++) owner_mark[entry_mem[i][31:16]] = 1;
        for (int t = 0; t < ID_SPACE; t++) begin
          seed = seed * LCG_MUL + LCG_INC;
          id = seed[15:0];
          if (id == NO_OWNER_ID || owner_mark[id]) continue;
          a.found = 1'b1;
          a.owner = id;
          break;
        end
      end
      K_WIPE: begin
        a.flag = op.ereq;
        for (int i = op.blk; i < n; i++) begin
          e = entry_mem[i];
          if (e[31:16] == NO_OWNER_ID) continue;
          er = op.ereq || e[15:0] == 0;
          entry_mem[i] = {16'(NO_OWNER_ID), er ? FS_ERASED : FS_GARBAGE};
          a.found = 1'b1;
          a.blk = i;
          a.flag = er;
          break;
        end
      end
      K_PENDING: begin
        for (int i = op.blk; i < n; i++) begin
          e = entry_mem[i];
          if (e[31:16] == NO_OWNER_ID && e[15:0] != FS_ERASED) begin
            entry_mem[i] = {16'(NO_OWNER_ID), FS_ERASED};
            a.found = 1'b1;
            a.blk = i;
            break;
          end
        end
      end
      K_VERSION: begin
        if (op.blk < n) begin
          a.found = 1'b1;
          a.blk = op.blk;
          a.flag = version_mem[op.blk];
        end
      end
      K_STATUS: begin
        a.full = 1'b1;
        for (int i = 0; i < n; i++) begin
          e = entry_mem[i];
          if (e[31:16] == NO_OWNER_ID) a.full = 1'b0;
          else a.used++;
          if (e == {16'(NO_OWNER_ID), FS_ERASED}) a.erased++;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report(string name, int unsigned got, int unsigned exp);
    if (got != exp) begin
      $display("%0t: %s got %0h expected %0h", $realtime, name, got, exp);
      error_count++;
    end
  endtask

  // result side
  always @(posedge clk_i) begin
    answer_t a;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_answers.size() == 0) begin
        report("result transfer with nothing outstanding", 1, 0);
      end else begin
        a = pending_answers.pop_front();
        report("found", m_axis_tuser_o[0], a.found);
        report("flag_out", m_axis_tuser_o[1], a.flag);
        report("table_full", m_axis_tuser_o[2], a.full);
        report("result_block", m_axis_tdata_o[9:0], a.blk);
        report("result_owner", m_axis_tdata_o[25:10], a.owner);
        report("next_start", m_axis_tdata_o[36:26], a.next_blk);
        report("part_count", m_axis_tdata_o[53:37], a.parts);
        report("used_count", m_axis_tdata_o[64:54], a.used);
        report("erased_count", m_axis_tdata_o[75:65], a.erased);
        report("zero pad", m_axis_tdata_o[79:76], 0);
      end
    end
    m_axis_tready_i <= !hold_on && ($urandom_range(99) >= sink_idle);
  end

  // long receiver stall
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_op(op_t op, bit typed, answer_t typed_ans);
    answer_t a;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {6'd0, op.part, op.owner, op.blk};
    s_axis_tuser_i <= {op.ereq, op.newf, op.blank, op.valid, op.kind};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    a = table_step(op);
    pending_answers.push_back(typed ? typed_ans : a);
  endtask

  task automatic set_blocks(int unsigned value);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value[10:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    blocks_cfg = value;
  endtask

  function automatic op_t rand_op(int unsigned n);
    op_t op;
    int unsigned r;
    int unsigned top;
    top = (n == 0) ? 0 : ((n > TABLE_SIZE) ? TABLE_SIZE - 1 : n - 1);
    r = $urandom_range(99);
    if (r < 30) op.kind = K_LOAD;
    else if (r < 96) op.kind = 4'($urandom_range(1, 11));
    else op.kind = 4'($urandom_range(12, 15));
    op.blk = ($urandom_range(9) < 8) ? 10'($urandom_range(top)) : 10'($urandom);
    r = $urandom_range(99);
    op.owner = (r < 85) ? 16'($urandom_range(1, 6)) : (r < 90) ? 16'(NO_OWNER_ID) : 16'($urandom);
    r = $urandom_range(99);
    op.part = (r < 85) ? 16'($urandom_range(3)) : 16'($urandom);
    op.valid = ($urandom_range(99) < 70);
    op.blank = $urandom_range(1);
    op.newf = $urandom_range(1);
    op.ereq = $urandom_range(1);
    return op;
  endfunction

  task automatic add_row(int cfg, logic [3:0] kind, logic [9:0] blk, logic [15:0] owner,
                         logic [15:0] part, logic [3:0] flags, bit typed, answer_t ans);
    row_t row;
    row.cfg = cfg;
    row.op = '{kind, blk, owner, part, flags[0], flags[1], flags[2], flags[3]};
    row.typed = typed;
    row.ans = ans;
    rows.push_back(row);
  endtask

  initial begin
    answer_t z;
    answer_t x;
    op_t     op;
    int unsigned phase_blocks [3] = '{64, 16, 48};
    z = '{default: '0};
    blocks_cfg = TABLE_SIZE;
    seed = '0;
    foreach (version_mem[i]) version_mem[i] = 1'b0;
    foreach (entry_mem[i]) entry_mem[i] = '0;
    src_idle = 0;
    sink_idle = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every covered block gets a scanned header before any scan runs
    set_blocks(PRELOAD);
    for (int i = 0; i < PRELOAD; i++) begin
      op = '{K_LOAD, 10'(i), 16'(i), 16'(i), 1'b0, 1'(i % 2), 1'b0, 1'b0};
      send_op(op, 0, z);
    end

    x = z; x.found = 1; x.blk = 10'(PRELOAD - 1);
    add_row(-1, K_LOAD, 10'(PRELOAD - 1), 16'hffff, 16'hffff, 4'b0101, 1, x);
    x = z; x.found = 1; x.blk = 0;
    add_row(-1, K_LOAD, 10'd0, 16'd5, 16'd0, 4'b0001, 1, x);
    add_row(-1, K_LOAD, 10'd1, 16'd5, 16'd1, 4'b0001, 0, z);
    add_row(-1, K_LOAD, 10'd2, 16'd9, 16'd3, 4'b1001, 0, z);
    add_row(-1, K_LOAD, 10'd3, 16'd0, 16'd0, 4'b0000, 0, z);
    add_row(-1, K_LOOKUP, 10'd0, 16'd5, 16'd1, 4'b0000, 0, z);
    add_row(-1, K_LOOKUP, 10'd0, 16'd0, 16'd1, 4'b0000, 0, z);
    x = z; x.found = 1; x.blk = 10'(PRELOAD - 1); x.flag = 1;
    add_row(-1, K_VERSION, 10'(PRELOAD - 1), 16'd0, 16'd0, 4'b0000, 1, x);
    add_row(-1, K_INFO, 10'd0, 16'hffff, 16'd0, 4'b0000, 0, z);
    add_row(-1, K_ITERATE, 10'd0, 16'd0, 16'd0, 4'b0000, 0, z);
    add_row(-1, K_PURGE, 10'd0, 16'd0, 16'd0, 4'b0000, 0, z);
    add_row(-1, K_ACQUIRE, 10'd0, 16'd7, 16'd0, 4'b0000, 0, z);
    add_row(-1, K_NEWID, 10'd0, 16'd0, 16'd0, 4'b0000, 0, z);
    add_row(-1, K_WIPE, 10'd0, 16'd0, 16'd0, 4'b0000, 0, z);
    add_row(-1, K_WIPE, 10'(PRELOAD - 1), 16'd0, 16'd0, 4'b1000, 0, z);
    add_row(-1, K_PENDING, 10'd0, 16'd0, 16'd0, 4'b0000, 0, z);
    add_row(-1, K_DELETE, 10'd0, 16'd5, 16'd0, 4'b0000, 0, z);
    add_row(-1, K_STATUS, 10'd0, 16'd0, 16'd0, 4'b0000, 0, z);
    add_row(-1, 4'd15, 10'd1023, 16'hffff, 16'hffff, 4'b1111, 1, z);
    add_row(0, K_LOAD, 10'd0, 16'd3, 16'd0, 4'b0001, 1, z);
    x = z; x.full = 1;
    add_row(-1, K_STATUS, 10'd0, 16'd0, 16'd0, 4'b0000, 1, x);
    add_row(-1, K_ACQUIRE, 10'd0, 16'd3, 16'd0, 4'b0000, 1, z);
    add_row(1, K_VERSION, 10'd1, 16'd0, 16'd0, 4'b0000, 1, z);
    add_row(-1, K_ITERATE, 10'd1, 16'd0, 16'd0, 4'b0000, 1, z);
    x = z; x.found = 1; x.blk = 1023;
    add_row(2047, K_LOAD, 10'd1023, 16'd4, 16'd0, 4'b0001, 1, x);
    x = z; x.found = 1; x.blk = 1023;
    add_row(-1, K_VERSION, 10'd1023, 16'd0, 16'd0, 4'b0000, 1, x);

    foreach (rows[i]) begin
      if (rows[i].cfg >= 0) set_blocks(rows[i].cfg);
      send_op(rows[i].op, rows[i].typed, rows[i].ans);
    end

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 18 : (ph == 1) ? 60 : 0;
      sink_idle = (ph == 0) ? 60 : (ph == 1) ? 18 : 0;
      if (ph == 1) begin
        set_blocks(PRELOAD);
        for (int i = 0; i < 12; i++) send_op(rand_op(PRELOAD), 0, z);
      end
      set_blocks(phase_blocks[ph]);
      for (int i = 0; i < 90; i++) begin
        if (ph == 2 && i == 40) hold_go = 1;
        if (ph == 1 && i == 45) set_blocks(1);
        if (ph == 1 && i == 50) set_blocks(16);
        send_op(rand_op(blocks_cfg), 0, z);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
